### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication on the same edge.
`define ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication at the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/spe_pkg.sv
// ----------------------------------------------------------------------------
// spe_pkg
// Types and constants of the shortest path engine.
// ----------------------------------------------------------------------------
package spe_pkg;

   localparam int NODES    = 32;
   localparam int EDGES    = 256;
   localparam int NODE_W   = $clog2(NODES);
   localparam int EADDR_W  = $clog2(EDGES);
   localparam int ECOUNT_W = EADDR_W + 1;
   localparam int SPAN_W   = NODE_W + 1;
   localparam int DIST_W   = 24;
   localparam int WEIGHT_W = 16;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   localparam logic [2:0] FUNC_CLEAR = 3'd0;
   localparam logic [2:0] FUNC_NODE  = 3'd1;
   localparam logic [2:0] FUNC_EDGE  = 3'd2;
   localparam logic [2:0] FUNC_OPEN  = 3'd3;
   localparam logic [2:0] FUNC_QUERY = 3'd4;
   localparam logic [2:0] FUNC_SOLVE = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_SPAN  = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [NODE_W-1:0]   a;
      logic [NODE_W-1:0]   b;
      logic [WEIGHT_W-1:0] w;
      logic                open;
   } edge_type;

   typedef struct packed {
      logic [DIST_W-1:0] cost;
      logic              reached;
      logic [NODE_W-1:0] parent;
      logic              has_parent;
      logic              done;
   } node_type;

   typedef struct packed {
      logic                found;
      logic [WEIGHT_W-1:0] edge_weight;
      logic                has_parent;
      logic [NODE_W-1:0]   parent_node;
      logic                reachable;
      logic [DIST_W-1:0]   distance;
      logic [NODE_W-1:0]   node;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_RESP, S_SO_RD, S_SO_WR, S_WQ_RD, S_WQ_CHK, S_CLR, S_SRC,
      S_MIN_RD, S_MIN_CHK, S_MARK, S_REL_ERD, S_REL_EDATA, S_REL_NDATA,
      S_EMIT_RD, S_EMIT_LD
   } state_type;

endpackage

### rtl/spe_ram.sv
// ----------------------------------------------------------------------------
// spe_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module spe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

### rtl/shortest_path_engine.sv
// ----------------------------------------------------------------------------
// shortest_path_engine
// Edge list graph store with a Dijkstra solver over open edges.
// ----------------------------------------------------------------------------
//   channel  dir  contents
//   req_     in   tuser func, tdata node_a/node_b/weight/open_flag
//   rsp_     out  tuser status, tdata result fields, tlast last
//
// One command at a time. Set open rewrites every matching stored edge; weight
// query scans the stored edges up to the first match. Solve clears the node
// table and seeds the source, then per pass searches the span for the minimum
// and relaxes over the stored edges from each finalized node; at the end it
// reports each node of the span.
// Reset is synchronous; a stalled result beat holds the engine.
module shortest_path_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // func
   input  logic [31:0] req_tdata,   // node_a, node_b, weight, open_flag, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // status
   output logic [55:0] rsp_tdata,   // node, distance, reachable, parent_node,
                                    // has_parent, edge_weight, found, zero fill
   output logic        rsp_tlast
);
   import spe_pkg::*;

   state_type state_ff, state_in;
   logic [NODE_W-1:0]   a_ff, a_in, b_ff, b_in, best_ff, best_in, v_ff, v_in;
   logic                open_ff, open_in, have_ff, have_in, bad_ff, bad_in;
   logic [ECOUNT_W-1:0] count_ff, count_in, eidx_ff, eidx_in;
   logic [SPAN_W-1:0]   span_ff, span_in, idx_ff, idx_in;
   logic [DIST_W-1:0]   du_ff, du_in;
   logic [NODE_W-1:0]   bpar_ff, bpar_in;
   logic                bpv_ff, bpv_in;
   logic [WEIGHT_W-1:0] w_ff, w_in, resw_ff, resw_in;
   logic                resf_ff, resf_in;
   logic [1:0]          ress_ff, ress_in;
   logic                rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   rsp_type             rsp_ff, rsp_in;

   logic                ewr_en, erd_en, nwr_en, nrd_en;
   logic [EADDR_W-1:0]  ewr_addr, erd_addr;
   logic [NODE_W-1:0]   nwr_addr, nrd_addr;
   edge_type            ewr_data, erd_data;
   node_type            nwr_data, nrd_data;

   logic [NODE_W-1:0]   ra, rb;
   logic [WEIGHT_W-1:0] rw;
   logic                ropen, out_free, match, hit;
   logic [SPAN_W-1:0]   span_a, span_b;
   logic [DIST_W:0]     sum;
   logic [DIST_W-1:0]   nd;

   spe_ram #(.WIDTH($bits(edge_type)), .DEPTH(EDGES)) u_edge_ram (
      .clock, .wr_en(ewr_en), .wr_addr(ewr_addr), .wr_data(ewr_data),
      .rd_en(erd_en), .rd_addr(erd_addr), .rd_data(erd_data));

   spe_ram #(.WIDTH($bits(node_type)), .DEPTH(NODES)) u_node_ram (
      .clock, .wr_en(nwr_en), .wr_addr(nwr_addr), .wr_data(nwr_data),
      .rd_en(nrd_en), .rd_addr(nrd_addr), .rd_data(nrd_data));

   assign ra    = req_tdata[4:0];
   assign rb    = req_tdata[9:5];
   assign rw    = req_tdata[25:10];
   assign ropen = req_tdata[26];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {3'b000, rsp_ff};
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign span_a = {1'b0, ra} + SPAN_W'(1);
   assign span_b = {1'b0, rb} + SPAN_W'(1);
   assign match  = (erd_data.a == a_ff && erd_data.b == b_ff) ||
                   (erd_data.a == b_ff && erd_data.b == a_ff);
   assign hit    = erd_data.open && (erd_data.a == best_ff || erd_data.b == best_ff);
   assign sum    = {1'b0, du_ff} + {{(DIST_W-WEIGHT_W+1){1'b0}}, w_ff};
   assign nd     = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];

   // sequencer
   always_comb begin
      state_in = state_ff;
      a_in = a_ff; b_in = b_ff; open_in = open_ff; best_in = best_ff; v_in = v_ff;
      have_in = have_ff; bad_in = bad_ff; count_in = count_ff; eidx_in = eidx_ff;
      span_in = span_ff; idx_in = idx_ff; du_in = du_ff; w_in = w_ff;
      bpar_in = bpar_ff; bpv_in = bpv_ff;
      resw_in = resw_ff; resf_in = resf_ff; ress_in = ress_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_last_in = rsp_last_ff; rsp_status_in = rsp_status_ff; rsp_in = rsp_ff;
      ewr_en = 1'b0; ewr_addr = count_ff[EADDR_W-1:0];
      ewr_data = '{a: ra, b: rb, w: rw, open: ropen};
      erd_en = 1'b0; erd_addr = eidx_ff[EADDR_W-1:0];
      nwr_en = 1'b0; nwr_addr = idx_ff[NODE_W-1:0];
      nwr_data = '{cost: DIST_MAX, reached: 1'b0, parent: '0, has_parent: 1'b0,
                   done: 1'b0};
      nrd_en = 1'b0; nrd_addr = idx_ff[NODE_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               a_in = ra; b_in = rb; open_in = ropen;
               resw_in = '0; resf_in = 1'b0; ress_in = ST_OK;
               idx_in = '0; eidx_in = '0; bad_in = 1'b0;
               state_in = S_RESP;
               case (req_tuser)
                  FUNC_CLEAR: begin
                     count_in = '0;
                     span_in  = '0;
                  end
                  FUNC_NODE: begin
                     if (span_a > span_ff) span_in = span_a;
                  end
                  FUNC_EDGE: begin
                     if (count_ff >= ECOUNT_W'(EDGES)) begin
                        ress_in = ST_FULL;
                     end else begin
                        ewr_en   = 1'b1;
                        count_in = count_ff + ECOUNT_W'(1);
                        if (span_a > span_ff || span_b > span_ff) begin
                           span_in = (span_a > span_b) ? span_a : span_b;
                        end
                     end
                  end
                  FUNC_OPEN, FUNC_QUERY: begin
                     if ({1'b0, ra} >= span_ff || {1'b0, rb} >= span_ff) begin
                        ress_in = ST_SPAN;
                     end else begin
                        state_in = (req_tuser == FUNC_OPEN) ? S_SO_RD : S_WQ_RD;
                     end
                  end
                  FUNC_SOLVE: begin
                     if (span_ff == '0) begin
                        ress_in = ST_SPAN;
                     end else if ({1'b0, ra} >= span_ff) begin
                        bad_in   = 1'b1;
                        state_in = S_EMIT_RD;
                     end else begin
                        state_in = S_CLR;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_status_in = ress_ff;
               rsp_in        = '0;
               rsp_in.edge_weight = resw_ff;
               rsp_in.found  = resf_ff;
               state_in      = S_IDLE;
            end
         end
         // set open: rewrite the open mark of every matching edge
         S_SO_RD: begin
            if (eidx_ff == count_ff) begin
               state_in = S_RESP;
            end else begin
               erd_en   = 1'b1;
               state_in = S_SO_WR;
            end
         end
         S_SO_WR: begin
            ewr_addr = eidx_ff[EADDR_W-1:0];
            ewr_data = erd_data;
            ewr_data.open = open_ff;
            ewr_en   = match;
            eidx_in  = eidx_ff + ECOUNT_W'(1);
            state_in = S_SO_RD;
         end
         // weight query: stop at the first matching edge
         S_WQ_RD: begin
            if (eidx_ff == count_ff) begin
               state_in = S_RESP;
            end else begin
               erd_en   = 1'b1;
               state_in = S_WQ_CHK;
            end
         end
         S_WQ_CHK: begin
            if (match) begin
               resw_in  = erd_data.w;
               resf_in  = 1'b1;
               state_in = S_RESP;
            end else begin
               eidx_in  = eidx_ff + ECOUNT_W'(1);
               state_in = S_WQ_RD;
            end
         end
         // solve: clear node table, seed the source
         S_CLR: begin
            nwr_en = 1'b1;
            idx_in = idx_ff + SPAN_W'(1);
            if (idx_ff == SPAN_W'(NODES - 1)) state_in = S_SRC;
         end
         S_SRC: begin
            nwr_en   = 1'b1;
            nwr_addr = a_ff;
            nwr_data.cost    = '0;
            nwr_data.reached = 1'b1;
            idx_in   = '0;
            have_in  = 1'b0;
            state_in = S_MIN_RD;
         end
         // minimum search over the span
         S_MIN_RD: begin
            nrd_en   = 1'b1;
            state_in = S_MIN_CHK;
         end
         S_MIN_CHK: begin
            if (nrd_data.reached && !nrd_data.done && (!have_ff || nrd_data.cost < du_ff))
            begin
               have_in = 1'b1;
               best_in = idx_ff[NODE_W-1:0];
               du_in   = nrd_data.cost;
               bpar_in = nrd_data.parent;
               bpv_in  = nrd_data.has_parent;
            end
            idx_in = idx_ff + SPAN_W'(1);
            if (idx_ff + SPAN_W'(1) == span_ff) begin
               idx_in   = '0;
               state_in = (have_in) ? S_MARK : S_EMIT_RD;
            end else begin
               state_in = S_MIN_RD;
            end
         end
         S_MARK: begin
            nwr_en   = 1'b1;
            nwr_addr = best_ff;
            nwr_data = '{cost: du_ff, reached: 1'b1, parent: bpar_ff,
                         has_parent: bpv_ff, done: 1'b1};
            eidx_in  = '0;
            state_in = S_REL_ERD;
         end
         // relax over the edge list
         S_REL_ERD: begin
            if (eidx_ff == count_ff) begin
               have_in  = 1'b0;
               idx_in   = '0;
               state_in = S_MIN_RD;
            end else begin
               erd_en   = 1'b1;
               state_in = S_REL_EDATA;
            end
         end
         S_REL_EDATA: begin
            if (hit) begin
               v_in     = (erd_data.a == best_ff) ? erd_data.b : erd_data.a;
               w_in     = erd_data.w;
               nrd_en   = 1'b1;
               nrd_addr = v_in;
               state_in = S_REL_NDATA;
            end else begin
               eidx_in  = eidx_ff + ECOUNT_W'(1);
               state_in = S_REL_ERD;
            end
         end
         S_REL_NDATA: begin
            if (!nrd_data.reached || nd < nrd_data.cost) begin
               nwr_en   = 1'b1;
               nwr_addr = v_ff;
               nwr_data = '{cost: nd, reached: 1'b1, parent: best_ff,
                            has_parent: 1'b1, done: nrd_data.done};
            end
            eidx_in  = eidx_ff + ECOUNT_W'(1);
            state_in = S_REL_ERD;
         end
         // report every node of the span
         S_EMIT_RD: begin
            if (out_free) begin
               nrd_en   = 1'b1;
               state_in = S_EMIT_LD;
            end
         end
         S_EMIT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = (idx_ff + SPAN_W'(1) == span_ff);
            rsp_in       = '0;
            rsp_in.node  = idx_ff[NODE_W-1:0];
            rsp_in.distance = DIST_MAX;
            if (bad_ff) begin
               rsp_status_in = ST_SPAN;
            end else begin
               rsp_status_in = ST_OK;
               if (nrd_data.reached) begin
                  rsp_in.reachable = 1'b1;
                  rsp_in.distance  = nrd_data.cost;
               end
               if (nrd_data.has_parent) begin
                  rsp_in.has_parent  = 1'b1;
                  rsp_in.parent_node = nrd_data.parent;
               end
            end
            idx_in   = idx_ff + SPAN_W'(1);
            state_in = rsp_last_in ? S_IDLE : S_EMIT_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         span_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         span_ff      <= span_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      a_ff <= a_in; b_ff <= b_in; open_ff <= open_in; best_ff <= best_in;
      v_ff <= v_in; have_ff <= have_in; bad_ff <= bad_in; eidx_ff <= eidx_in;
      idx_ff <= idx_in; du_ff <= du_in; w_ff <= w_in; bpar_ff <= bpar_in;
      bpv_ff <= bpv_in; resw_ff <= resw_in; resf_ff <= resf_in; ress_ff <= ress_in;
      rsp_last_ff <= rsp_last_in; rsp_status_ff <= rsp_status_in; rsp_ff <= rsp_in;
   end

endmodule

### rtl/spe_checker.sv
// ----------------------------------------------------------------------------
// spe_checker
// Port-level checks of the shortest path engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [2:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [1:0]  rsp_tuser,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tlast
);
   import spe_pkg::*;

   // hold a stalled beat
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // one command in flight: a known command closes the input
   `ASSERT_NEXT(a_busy, clock, reset,
      req_tvalid && req_tready && req_tuser <= FUNC_SOLVE, !req_tready)
   // a found weight is a single ok beat
   `ASSERT_NOW(a_found, clock, reset, rsp_tvalid && rsp_tdata[52],
      rsp_tlast && rsp_tuser == ST_OK)
   // a parent implies reached
   `ASSERT_NOW(a_parent, clock, reset, rsp_tvalid && rsp_tdata[35], rsp_tdata[29])

endmodule

bind shortest_path_engine spe_checker u_spe_checker (.*);
